### design/hts_pkg.sv
`default_nettype none
package hts_pkg;
  localparam int INDEX_BITS_DEF = 20;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int STAGE_LIMIT = 24;
  localparam logic [31:0] TURNS_PER_RAD = 32'd683565276;
  localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
  localparam logic [62:0] MAG_CAP = 63'h4000_0000_0000_0000;

  typedef enum logic [2:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_RADIUS = 3'd2,
    REG_BASE_HEIGHT = 3'd3,
    REG_CLIMB_RATE = 3'd4,
    REG_TURN_RATE = 3'd5,
    REG_SAMPLE_PERIOD = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic [30:0] radius;
    logic signed [31:0] base_height;
    logic signed [31:0] climb_rate;
    logic signed [31:0] turn_rate;
    logic [31:0] sample_period;
  } cfg_t;

  function automatic logic [31:0] atan_turn(input int k);
    logic [31:0] v;
    case (k)
      0: v = 32'd536870912;
      1: v = 32'd316933406;
      2: v = 32'd167458907;
      3: v = 32'd85004756;
      4: v = 32'd42667331;
      5: v = 32'd21354465;
      6: v = 32'd10679838;
      7: v = 32'd5340245;
      8: v = 32'd2670163;
      9: v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // Round a 64-bit product down by sh bits, ties up, held at the cap.
  function automatic logic [62:0] round_cap(input logic [63:0] p, input int sh);
    logic [64:0] s;
    logic [64:0] q;
    s = {1'b0, p} + (65'd1 << (sh - 1));
    q = s >> sh;
    if (q > {2'b0, MAG_CAP}) return MAG_CAP;
    return q[62:0];
  endfunction

  function automatic logic [31:0] sat_signed(input logic [62:0] mag, input logic neg,
                                             input logic signed [31:0] base);
    logic signed [64:0] v;
    v = neg ? -$signed({2'b0, mag}) : $signed({2'b0, mag});
    v = v + 65'(base);
    if (v > 65'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -65'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction
endpackage
`default_nettype wire

### design/hts_if.sv
`default_nettype none
interface hts_in_if #(parameter int INDEX_BITS = hts_pkg::INDEX_BITS_DEF);
  logic valid;
  logic ready;
  logic [INDEX_BITS-1:0] sample_index;
  modport source(output valid, output sample_index, input ready);
  modport sink(input valid, input sample_index, output ready);
endinterface

interface hts_out_if;
  logic valid;
  logic ready;
  logic [31:0] stamp;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [31:0] pos_z;
  logic [31:0] vel_x;
  logic [31:0] vel_y;
  logic [31:0] vel_z;
  logic [31:0] acc_x;
  logic [31:0] acc_y;
  modport source(output valid, output stamp, output pos_x, output pos_y, output pos_z,
                 output vel_x, output vel_y, output vel_z, output acc_x, output acc_y,
                 input ready);
  modport sink(input valid, input stamp, input pos_x, input pos_y, input pos_z,
               input vel_x, input vel_y, input vel_z, input acc_x, input acc_y,
               output ready);
endinterface

interface hts_cfg_if;
  logic valid;
  logic ready;
  logic [2:0] index;
  logic [31:0] data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### design/hts_cordic.sv
`default_nettype none
// One rotation per stage; the pipeline advances when en is high.
module hts_cordic #(
  parameter int STAGES = 16
) (
  input wire clk,
  input wire en,
  input wire [31:0] phase,
  output logic signed [33:0] cos_out,
  output logic signed [33:0] sin_out
);
  import hts_pkg::*;
  localparam int N = (STAGES > STAGE_LIMIT) ? STAGE_LIMIT : STAGES;

  logic signed [33:0] xs [0:N];
  logic signed [33:0] ys [0:N];
  logic signed [32:0] zs [0:N];
  logic flip [0:N];

  logic [1:0] quad;
  logic [31:0] u;
  assign quad = phase[31:30];
  assign u = (quad == 2'd1 || quad == 2'd2) ? phase - 32'h8000_0000 : phase;

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= GAIN_Q30;
      ys[0] <= '0;
      zs[0] <= 33'($signed(u));
      flip[0] <= (quad == 2'd1 || quad == 2'd2);
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [32:0] a;
    assign dx = ys[k] >>> k;
    assign dy = xs[k] >>> k;
    assign a = 33'(atan_turn(k));
    always_ff @(posedge clk) begin
      if (en) begin
        flip[k+1] <= flip[k];
        if (!zs[k][32]) begin
          xs[k+1] <= xs[k] - dx;
          ys[k+1] <= ys[k] + dy;
          zs[k+1] <= zs[k] - a;
        end else begin
          xs[k+1] <= xs[k] + dx;
          ys[k+1] <= ys[k] - dy;
          zs[k+1] <= zs[k] + a;
        end
      end
    end
  end

  assign cos_out = flip[N] ? -xs[N] : xs[N];
  assign sin_out = flip[N] ? -ys[N] : ys[N];
endmodule
`default_nettype wire

### design/helical_trajectory_sampler.sv
`default_nettype none
// An accepted index passes the stamp, time product, phase parts and phase stages, the
// CORDIC input register and rotation stages, then the magnitude, product and rounding stages.
// Throughput: one index per cycle; the pipeline stalls as a whole when the
// output word is not taken.
// Reset (rst, synchronous) clears the configuration registers to zero and empties
// the pipeline.
module helical_trajectory_sampler #(
  parameter int INDEX_BITS = hts_pkg::INDEX_BITS_DEF,
  parameter int CORDIC_STAGES = hts_pkg::CORDIC_STAGES_DEF
) (
  input wire clk,
  input wire rst,
  hts_cfg_if.sink cfg,
  hts_in_if.sink in_ch,
  hts_out_if.source out_ch
);
  import hts_pkg::*;
  localparam int N = (CORDIC_STAGES > STAGE_LIMIT) ? STAGE_LIMIT : CORDIC_STAGES;
  localparam int PRE = 4;      // stamp, time product, phase parts, phase
  localparam int DEPTH = PRE + 1 + N + 3;

  cfg_t regs;
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_CENTER_X: regs.center_x <= cfg.data;
        REG_CENTER_Y: regs.center_y <= cfg.data;
        REG_RADIUS: regs.radius <= cfg.data[30:0];
        REG_BASE_HEIGHT: regs.base_height <= cfg.data;
        REG_CLIMB_RATE: regs.climb_rate <= cfg.data;
        REG_TURN_RATE: regs.turn_rate <= cfg.data;
        REG_SAMPLE_PERIOD: regs.sample_period <= cfg.data;
        default: ;
      endcase
    end
  end

  logic [DEPTH-1:0] vld;
  logic en;
  assign en = !vld[DEPTH-1] || out_ch.ready;
  assign in_ch.ready = en;
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[DEPTH-2:0], in_ch.valid};
  end

  logic [31:0] om;
  logic oneg;
  assign oneg = regs.turn_rate[31];
  assign om = oneg ? 32'(-regs.turn_rate) : regs.turn_rate;

  // Stage 1: stamp.
  logic [INDEX_BITS-1:0] idx;
  logic [31:0] stamp1;
  logic [63:0] sprod;
  assign idx = in_ch.sample_index;
  assign sprod = 64'(idx) * 64'(regs.sample_period);
  always_ff @(posedge clk) if (en) stamp1 <= (sprod[63:32] != 0) ? 32'hFFFF_FFFF : sprod[31:0];

  // Stage 2: time * omega.
  logic [31:0] stamp2;
  logic [63:0] tm2;
  always_ff @(posedge clk) if (en) begin
    stamp2 <= stamp1;
    tm2 <= 64'(om) * 64'(stamp1);
  end

  // Stage 3: partial products into turns.
  logic [31:0] stamp3;
  logic [31:0] ph_hi3;
  logic [31:0] ph_lo3;
  logic [63:0] lo_prod;
  logic [63:0] hi_prod;
  assign lo_prod = 64'(tm2[31:0]) * 64'(TURNS_PER_RAD);
  assign hi_prod = 64'(tm2[63:32]) * 64'(TURNS_PER_RAD);
  always_ff @(posedge clk) if (en) begin
    stamp3 <= stamp2;
    ph_hi3 <= hi_prod[31:0];
    ph_lo3 <= lo_prod[63:32];
  end

  // Stage 4: phase.
  logic [31:0] stamp4;
  logic [31:0] phase4;
  logic [31:0] ph_sum;
  assign ph_sum = ph_hi3 + ph_lo3;
  always_ff @(posedge clk) if (en) begin
    stamp4 <= stamp3;
    phase4 <= oneg ? -ph_sum : ph_sum;
  end

  logic signed [33:0] cs;
  logic signed [33:0] sn;
  hts_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
    .clk(clk), .en(en), .phase(phase4), .cos_out(cs), .sin_out(sn)
  );

  // Stamp delay line alongside the CORDIC.
  logic [31:0] sdl [0:N];
  always_ff @(posedge clk) if (en) sdl[0] <= stamp4;
  for (genvar k = 0; k < N; k++) begin : g_sdl
    always_ff @(posedge clk) if (en) sdl[k+1] <= sdl[k];
  end

  // Constant-per-config scale factors, recomputed every cycle.
  logic [62:0] rw;
  logic [63:0] rwp;
  logic [62:0] rw_r;
  assign rwp = 64'(regs.radius) * 64'(om);
  assign rw = round_cap(rwp, 16);
  always_ff @(posedge clk) rw_r <= rw;

  // r*omega^2 is built from two 32-bit partial products of r*omega.
  logic [63:0] rw2_lo;
  logic [63:0] rw2_hi;
  always_ff @(posedge clk) begin
    rw2_lo <= 64'(rw_r[31:0]) * 64'(om);
    rw2_hi <= 64'(rw_r[62:32]) * 64'(om);
  end
  logic [64:0] rw2_sum;
  logic [62:0] rw2;
  assign rw2_sum = {rw2_hi[48:0], 16'b0} + 65'((rw2_lo + 64'h8000) >> 16);
  assign rw2 = (rw2_hi[63:46] != 0 || rw2_sum > {2'b0, MAG_CAP}) ? MAG_CAP : rw2_sum[62:0];
  logic [62:0] rw2_r;
  always_ff @(posedge clk) rw2_r <= rw2;

  // Stage A: magnitudes.
  logic [31:0] cm;
  logic [31:0] sm;
  logic cneg;
  logic sneg;
  logic [31:0] stampa;
  always_ff @(posedge clk) if (en) begin
    cneg <= cs[33];
    sneg <= sn[33];
    cm <= cs[33] ? 32'(-cs) : cs[31:0];
    sm <= sn[33] ? 32'(-sn) : sn[31:0];
    stampa <= sdl[N];
  end

  // Stage B: products. rw and rw2 are split into a 32-bit low part and a 31-bit high part.
  logic [63:0] p_rc, p_rs, p_z, p_vsl, p_vsh, p_vcl, p_vch, p_asl, p_ash, p_acl, p_ach;
  logic cnegb, snegb, zneg;
  logic [31:0] stampb;
  logic [31:0] climb_m;
  assign zneg = regs.climb_rate[31];
  assign climb_m = zneg ? 32'(-regs.climb_rate) : regs.climb_rate;
  always_ff @(posedge clk) if (en) begin
    cnegb <= cneg;
    snegb <= sneg;
    stampb <= stampa;
    p_rc <= 64'(regs.radius) * 64'(cm);
    p_rs <= 64'(regs.radius) * 64'(sm);
    p_z <= 64'(climb_m) * 64'(stampa);
    p_vsl <= 64'(rw_r[31:0]) * 64'(sm);
    p_vsh <= 64'(rw_r[62:32]) * 64'(sm);
    p_vcl <= 64'(rw_r[31:0]) * 64'(cm);
    p_vch <= 64'(rw_r[62:32]) * 64'(cm);
    p_asl <= 64'(rw2_r[31:0]) * 64'(sm);
    p_ash <= 64'(rw2_r[62:32]) * 64'(sm);
    p_acl <= 64'(rw2_r[31:0]) * 64'(cm);
    p_ach <= 64'(rw2_r[62:32]) * 64'(cm);
  end

  function automatic logic [62:0] mr30(input logic [63:0] hi, input logic [63:0] lo);
    logic [64:0] r;
    if (hi[63:60] != 0) return MAG_CAP;
    r = {hi[60:0], 2'b0} + 65'((lo + 64'h2000_0000) >> 30);
    if (r > {2'b0, MAG_CAP}) return MAG_CAP;
    return r[62:0];
  endfunction

  // Stage C: rounding, sign and saturation.
  logic [31:0] o_stamp, o_px, o_py, o_pz, o_vx, o_vy, o_vz, o_ax, o_ay;
  always_ff @(posedge clk) if (en) begin
    o_stamp <= stampb;
    o_px <= sat_signed(round_cap(p_rc, 30), cnegb, regs.center_x);
    o_py <= sat_signed(round_cap(p_rs, 30), snegb, regs.center_y);
    o_pz <= sat_signed(round_cap(p_z, 16), zneg, regs.base_height);
    o_vx <= sat_signed(mr30(p_vsh, p_vsl), !(oneg != snegb), 32'sd0);
    o_vy <= sat_signed(mr30(p_vch, p_vcl), oneg != cnegb, 32'sd0);
    o_vz <= regs.climb_rate;
    o_ax <= sat_signed(mr30(p_ach, p_acl), !cnegb, 32'sd0);
    o_ay <= sat_signed(mr30(p_ash, p_asl), !snegb, 32'sd0);
  end

  assign out_ch.valid = vld[DEPTH-1];
  assign out_ch.stamp = o_stamp;
  assign out_ch.pos_x = o_px;
  assign out_ch.pos_y = o_py;
  assign out_ch.pos_z = o_pz;
  assign out_ch.vel_x = o_vx;
  assign out_ch.vel_y = o_vy;
  assign out_ch.vel_z = o_vz;
  assign out_ch.acc_x = o_ax;
  assign out_ch.acc_y = o_ay;

  // A stalled output word must be held until taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.pos_x))
    else $error("output word changed under stall");
  // The pipeline only advances when the last stage is free.
  a_adv: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready == (!out_ch.valid || out_ch.ready))
    else $error("input ready disagrees with output stall");
  a_vz: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.vel_z == regs.climb_rate)
    else $error("vertical speed mismatch");
endmodule
`default_nettype wire

### bench/helical_trajectory_sampler_tb.sv
`timescale 1ns / 1ps
module helical_trajectory_sampler_tb;
  import hts_pkg::*;

  localparam int IDX_W = 20;
  localparam int STAGES = 16;
  localparam int LATENCY = 8 + STAGES;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    logic [31:0] stamp, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, acc_x, acc_y;
  } sample_t;

  typedef struct {
    logic is_cfg;
    logic [2:0] index;
    logic [31:0] data;
  } stim_t;

  logic clk = 0;
  logic rst = 1;
  always #4 clk = ~clk;

  hts_cfg_if cfg_ch();
  hts_in_if #(.INDEX_BITS(IDX_W)) in_ch();
  hts_out_if out_ch();

  helical_trajectory_sampler #(.INDEX_BITS(IDX_W), .CORDIC_STAGES(STAGES)) DUT (
    .clk(clk), .rst(rst), .cfg(cfg_ch.sink), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  logic [31:0] shadow [7];
  sample_t expected_samples[$];
  logic [IDX_W-1:0] pending_indices[$];
  int errors = 0;
  int n_mismatch = 0;
  longint cycles = 0;
  bit calm = 0;
  int hold_off = 0;
  bit in_acc = 0;
  bit cfg_acc = 0;

  logic [31:0] atan_tab [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  function automatic logic [63:0] mround(logic [63:0] a, logic [63:0] b, int sh);
    logic [127:0] p;
    p = a * b;
    p = (p + (128'd1 << (sh - 1))) >> sh;
    if (p > (128'd1 << 62)) p = 128'd1 << 62;
    return p[63:0];
  endfunction

  function automatic logic [31:0] clamp32(longint base, logic [63:0] mag, logic neg);
    logic signed [65:0] v;
    v = neg ? -$signed({2'b0, mag}) : $signed({2'b0, mag});
    v = v + base;
    if (v > 66'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -66'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic sample_t trajectory_point(logic [IDX_W-1:0] idx);
    sample_t r;
    logic [63:0] prod, stamp, om, tm, phase, rad, rw, rw2, cm, sm, u;
    longint omega, climb, x, y, z, dx, dy;
    logic oneg, flip, cneg, sneg;
    logic [1:0] q;
    prod = 64'(idx) * 64'(shadow[REG_SAMPLE_PERIOD]);
    stamp = prod > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : prod;
    omega = longint'($signed(shadow[REG_TURN_RATE]));
    oneg = omega < 0;
    om = oneg ? -omega : omega;
    tm = om * stamp;
    phase = ((tm >> 32) * 64'd683565276 + (((tm & 64'hFFFF_FFFF) * 64'd683565276) >> 32))
            & 64'hFFFF_FFFF;
    if (oneg) phase = (-phase) & 64'hFFFF_FFFF;
    q = phase[31:30];
    flip = (q == 2'd1) || (q == 2'd2);
    u = flip ? ((phase - 64'h8000_0000) & 64'hFFFF_FFFF) : phase;
    z = longint'($signed(u[31:0]));
    x = 652032874;
    y = 0;
    for (int k = 0; k < STAGES && k < 24; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[k];
      end else begin
        x += dx; y -= dy; z += atan_tab[k];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    cneg = x < 0; sneg = y < 0;
    cm = cneg ? -x : x;
    sm = sneg ? -y : y;
    rad = {33'b0, shadow[REG_RADIUS][30:0]};
    rw = mround(rad, om, 16);
    rw2 = mround(rw, om, 16);
    climb = longint'($signed(shadow[REG_CLIMB_RATE]));
    r.stamp = stamp[31:0];
    r.pos_x = clamp32($signed(shadow[REG_CENTER_X]), mround(rad, cm, 30), cneg);
    r.pos_y = clamp32($signed(shadow[REG_CENTER_Y]), mround(rad, sm, 30), sneg);
    r.pos_z = clamp32($signed(shadow[REG_BASE_HEIGHT]),
                      mround(climb < 0 ? -climb : climb, stamp, 16), climb < 0);
    r.vel_x = clamp32(0, mround(rw, sm, 30), !(oneg != sneg));
    r.vel_y = clamp32(0, mround(rw, cm, 30), oneg != cneg);
    r.vel_z = shadow[REG_CLIMB_RATE];
    r.acc_x = clamp32(0, mround(rw2, cm, 30), !cneg);
    r.acc_y = clamp32(0, mround(rw2, sm, 30), !sneg);
    return r;
  endfunction

  stim_t stim_queue[$];

  // Driver: one queue feeds both the register port and the index channel, so
  // register writes are held back until the pipeline has drained.
  int drain_wait = 0;
  always @(negedge clk) begin
    if (rst) begin
      cfg_ch.valid <= 0;
      in_ch.valid <= 0;
    end else begin
      if (cfg_ch.valid && cfg_acc) cfg_ch.valid <= 0;
      if (in_ch.valid && in_acc) in_ch.valid <= 0;
      if ((!cfg_ch.valid || cfg_acc) && (!in_ch.valid || in_acc)
          && stim_queue.size() > 0) begin
        if (stim_queue[0].is_cfg) begin
          if (expected_samples.size() != 0 || in_acc) begin
            drain_wait = 0;
          end else if (drain_wait < LATENCY + 4) begin
            drain_wait++;
          end else begin
            stim_t s;
            s = stim_queue.pop_front();
            cfg_ch.valid <= 1;
            cfg_ch.index <= s.index;
            cfg_ch.data <= s.data;
            if (s.index < 7) shadow[s.index] = s.index == REG_RADIUS ?
                                               {1'b0, s.data[30:0]} : s.data;
            drain_wait = 0;
          end
        end else if (calm || $urandom_range(99) >= 15) begin
          stim_t s;
          s = stim_queue.pop_front();
          in_ch.valid <= 1;
          in_ch.sample_index <= s.data[IDX_W-1:0];
          expected_samples.insert(expected_samples.size(),
                                  trajectory_point(s.data[IDX_W-1:0]));
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst) out_ch.ready <= 0;
    else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ch.ready <= 0;
    end else out_ch.ready <= calm || $urandom_range(99) >= 15;
  end

  task automatic report(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      n_mismatch++;
      if (n_mismatch <= 10)
        $display("mismatch %s: expected %h actual %h", name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    in_acc <= !rst && in_ch.valid && in_ch.ready;
    cfg_acc <= !rst && cfg_ch.valid && cfg_ch.ready;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_samples.size() == 0) begin
        errors++;
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("unexpected output word, stamp %h", out_ch.stamp);
      end else begin
        sample_t e;
        e = expected_samples.pop_front();
        report("stamp", e.stamp, out_ch.stamp);
        report("pos_x", e.pos_x, out_ch.pos_x);
        report("pos_y", e.pos_y, out_ch.pos_y);
        report("pos_z", e.pos_z, out_ch.pos_z);
        report("vel_x", e.vel_x, out_ch.vel_x);
        report("vel_y", e.vel_y, out_ch.vel_y);
        report("vel_z", e.vel_z, out_ch.vel_z);
        report("acc_x", e.acc_x, out_ch.acc_x);
        report("acc_y", e.acc_y, out_ch.acc_y);
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic add_write(reg_idx_t r, logic [31:0] d);
    stim_queue.insert(stim_queue.size(), '{1'b1, r, d});
  endtask

  task automatic add_raw_write(logic [2:0] r, logic [31:0] d);
    stim_queue.insert(stim_queue.size(), '{1'b1, r, d});
  endtask

  task automatic add_index(logic [31:0] i);
    stim_queue.insert(stim_queue.size(), '{1'b0, 3'd0, i});
  endtask

  task automatic random_setting(int kind);
    add_write(REG_CENTER_X, kind == 0 ? 32'h7FFF_FFFF : $urandom);
    add_write(REG_CENTER_Y, kind == 0 ? 32'h8000_0000 : $urandom);
    add_write(REG_RADIUS, kind == 0 ? 32'hFFFF_FFFF : ($urandom_range(1) ? $urandom
                                                       : $urandom_range(32'h40_0000)));
    add_write(REG_BASE_HEIGHT, $urandom);
    add_write(REG_CLIMB_RATE, kind == 0 ? 32'h8000_0000 : $urandom_range(1) ?
              $urandom : $urandom_range(32'h2_0000) - 32'h1_0000);
    add_write(REG_TURN_RATE, kind == 0 ? 32'h7FFF_FFFF : $urandom_range(1) ?
              $urandom : $urandom_range(32'h8_0000) - 32'h4_0000);
    add_write(REG_SAMPLE_PERIOD, kind == 0 ? 32'hFFFF_FFFF : $urandom_range(1) ?
              $urandom : $urandom_range(32'h2000));
  endtask

  initial begin
    foreach (shadow[k]) shadow[k] = 0;
    cfg_ch.valid = 0; cfg_ch.index = 0; cfg_ch.data = 0;
    in_ch.valid = 0; in_ch.sample_index = 0;
    out_ch.ready = 0;

    // Reset values, then a moderate helix, then the extremes.
    add_index(0); add_index(20'hFFFFF);
    add_write(REG_CENTER_X, 32'h0001_0000);
    add_write(REG_CENTER_Y, 32'hFFFF_0000);
    add_write(REG_RADIUS, 32'h0002_0000);
    add_write(REG_BASE_HEIGHT, 32'h0000_8000);
    add_write(REG_CLIMB_RATE, 32'h0000_4000);
    add_write(REG_TURN_RATE, 32'h0001_0000);
    add_write(REG_SAMPLE_PERIOD, 32'h0000_0CCD);
    add_raw_write(3'd7, 32'hFFFF_FFFF);
    for (int i = 0; i < 8; i++) add_index(i * 20);
    add_index(20'hFFFFF);
    add_write(REG_TURN_RATE, 32'hFFFF_0000);
    add_index(7); add_index(100);
    add_write(REG_SAMPLE_PERIOD, 0);
    add_index(12345);
    random_setting(0);
    add_index(0); add_index(1); add_index(20'hFFFFF); add_index(20'hAAAAA);
    add_index(20'h55555);
    add_write(REG_TURN_RATE, 32'h8000_0000);
    add_write(REG_CLIMB_RATE, 32'h7FFF_FFFF);
    add_index(3); add_index(20'hFFFFF);

    for (int p = 0; p < 7; p++) begin
      random_setting(1);
      for (int i = 0; i < 100; i++)
        add_index($urandom_range(3) == 0 ? $urandom : $urandom_range(4000));
    end

    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    calm = 1;
    repeat (300) @(posedge clk);
    calm = 0;
    @(negedge clk);
    hold_off <= 200;
    while (stim_queue.size() > 0 || in_ch.valid) @(posedge clk);
    while (expected_samples.size() > 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
